### rtl/rme_pkg.sv
// Shared types and constants for the modular exponentiation unit.
package rme_pkg;

  localparam int FIELD_BITS    = 32;
  localparam int CFG_ADDR_BITS = 8;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_EXPONENT = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MODULUS  = CFG_ADDR_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic run;
    logic reduce;
    logic add_phase;
    logic pass_end;
  } ctl_t;

endpackage

### rtl/rme_cell.sv
// Bit-serial interleaved modular multiply accumulator.
module rme_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 clr_i,
  input  logic                 en_i,
  input  logic                 add_phase_i,
  input  logic                 bit_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS:0]   mod_i,
  output logic [WORD_BITS-1:0] acc_nxt_o
);

  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   diff;

  always_comb begin
    if (add_phase_i) begin
      sum = {1'b0, acc_r} + {1'b0, (bit_i ? a_i : '0)};
    end else begin
      sum = {acc_r, 1'b0};
    end
    diff = sum - mod_i;
    if (sum >= mod_i) begin
      acc_nxt_o = diff[WORD_BITS-1:0];
    end else begin
      acc_nxt_o = sum[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_i) begin
      acc_r <= '0;
    end else if (en_i) begin
      acc_r <= acc_nxt_o;
    end
  end

endmodule

### rtl/rme_seq.sv
// Sequencer: pass control, digit counter and handshake state.
module rme_seq #(
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          exp_zero_i,
  input  logic          exp_rest_zero_i,
  output rme_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          done_o
);

  localparam int CNT_BITS = $clog2(2 * WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(2 * WORD_BITS - 1);

  rme_pkg::state_t     state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                last;

  assign last = (cnt_r == CNT_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      rme_pkg::ST_IDLE, rme_pkg::ST_DONE: begin
        if (start) begin
          state_nxt = exp_zero_i ? rme_pkg::ST_DONE : rme_pkg::ST_REDUCE;
        end else begin
          state_nxt = rme_pkg::ST_IDLE;
        end
      end
      rme_pkg::ST_REDUCE: begin
        if (last) begin
          state_nxt = rme_pkg::ST_STEP;
        end
      end
      rme_pkg::ST_STEP: begin
        if (last && exp_rest_zero_i) begin
          state_nxt = rme_pkg::ST_DONE;
        end
      end
      default: state_nxt = rme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    busy_o = 1'b0;
    done_o = 1'b0;
    unique case (state_r)
      rme_pkg::ST_IDLE: begin
        ctl_o.accept = start;
      end
      rme_pkg::ST_DONE: begin
        ctl_o.accept = start;
        done_o       = 1'b1;
      end
      rme_pkg::ST_REDUCE: begin
        busy_o          = 1'b1;
        ctl_o.run       = 1'b1;
        ctl_o.reduce    = 1'b1;
        ctl_o.add_phase = cnt_r[0];
        ctl_o.pass_end  = last;
      end
      rme_pkg::ST_STEP: begin
        busy_o          = 1'b1;
        ctl_o.run       = 1'b1;
        ctl_o.add_phase = cnt_r[0];
        ctl_o.pass_end  = last;
      end
      default: ctl_o = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl_o.accept || (ctl_o.run && last)) begin
      cnt_nxt = '0;
    end else if (ctl_o.run) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rme_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_accept_enters_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.accept && !exp_zero_i |=> state_r == rme_pkg::ST_REDUCE)
    else $error("accepted beat did not start reduction");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rme_pkg::ST_STEP && ctl_o.pass_end && exp_rest_zero_i
      |=> state_r == rme_pkg::ST_DONE)
    else $error("final exponent bit did not finish");

  a_pass_ends_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.pass_end |-> ctl_o.add_phase && ctl_o.run)
    else $error("pass ended off the add phase");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_o && !start |=> !done_o && !busy_o)
    else $error("result strobe held too long");

endmodule

### rtl/rsa_modular_exponentiation_unit.sv
// Top level: value ^ exponent mod modulus by right-to-left square-and-multiply.
// A zero exponent goes straight to done; else a reduction pass runs, then one
// multiply and one square in parallel per exponent bit up to the highest set bit.
// A new beat is taken in the cycle that shows the previous result.
// out_valid lasts one cycle, unless that new beat has a zero exponent.
// Synchronous reset: idle, exponent 1, modulus all ones.
module rsa_modular_exponentiation_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rme_pkg::FIELD_BITS-1:0]      in_value_in,
  output logic                                out_valid,
  output logic [rme_pkg::FIELD_BITS-1:0]      out_value_out,
  input  logic                                cfg_we,
  input  logic [rme_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [rme_pkg::FIELD_BITS-1:0]      cfg_data
);

  logic [WORD_BITS-1:0] exponent_r, exponent_nxt;
  logic [WORD_BITS-1:0] modulus_r, modulus_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt;
  logic [WORD_BITS-1:0] base_r, base_nxt;
  logic [WORD_BITS-1:0] bsh_r, bsh_nxt;
  logic [WORD_BITS-1:0] exp_sh_r, exp_sh_nxt;

  logic [WORD_BITS:0]   mod_ext;
  logic [WORD_BITS-1:0] one_mod;
  logic [WORD_BITS-1:0] mul_a;
  logic [WORD_BITS-1:0] mul_nxt;
  logic [WORD_BITS-1:0] sqr_nxt;
  logic                 exp_zero;
  logic                 exp_rest_zero;
  logic                 done;
  logic                 cell_clr;
  rme_pkg::ctl_t        ctl;

  assign mod_ext       = (modulus_r == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, modulus_r};
  assign one_mod       = (mod_ext == (WORD_BITS+1)'(1)) ? '0 : WORD_BITS'(1);
  assign mul_a         = ctl.reduce ? one_mod : res_r;
  assign exp_zero      = (exponent_r == '0);
  assign exp_rest_zero = (exp_sh_r[WORD_BITS-1:1] == '0);
  assign cell_clr      = ctl.accept || ctl.pass_end;

  rme_seq #(.WORD_BITS(WORD_BITS)) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .exp_zero_i      (exp_zero),
    .exp_rest_zero_i (exp_rest_zero),
    .ctl_o           (ctl),
    .busy_o          (busy),
    .done_o          (done)
  );

  rme_cell #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk         (clk),
    .clr_i       (cell_clr),
    .en_i        (ctl.run),
    .add_phase_i (ctl.add_phase),
    .bit_i       (bsh_r[WORD_BITS-1]),
    .a_i         (mul_a),
    .mod_i       (mod_ext),
    .acc_nxt_o   (mul_nxt)
  );

  rme_cell #(.WORD_BITS(WORD_BITS)) u_sqr (
    .clk         (clk),
    .clr_i       (cell_clr),
    .en_i        (ctl.run),
    .add_phase_i (ctl.add_phase),
    .bit_i       (bsh_r[WORD_BITS-1]),
    .a_i         (base_r),
    .mod_i       (mod_ext),
    .acc_nxt_o   (sqr_nxt)
  );

  always_comb begin
    exponent_nxt = exponent_r;
    modulus_nxt  = modulus_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        rme_pkg::CFG_EXPONENT: exponent_nxt = cfg_data[WORD_BITS-1:0];
        rme_pkg::CFG_MODULUS:  modulus_nxt  = cfg_data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt    = res_r;
    base_nxt   = base_r;
    bsh_nxt    = bsh_r;
    exp_sh_nxt = exp_sh_r;
    if (ctl.accept) begin
      res_nxt    = WORD_BITS'(1);
      bsh_nxt    = in_value_in[WORD_BITS-1:0];
      exp_sh_nxt = exponent_r;
    end else if (ctl.pass_end && ctl.reduce) begin
      base_nxt = mul_nxt;
      bsh_nxt  = mul_nxt;
    end else if (ctl.pass_end) begin
      base_nxt   = sqr_nxt;
      bsh_nxt    = sqr_nxt;
      exp_sh_nxt = exp_sh_r >> 1;
      if (exp_sh_r[0]) begin
        res_nxt = mul_nxt;
      end
    end else if (ctl.run && ctl.add_phase) begin
      bsh_nxt = bsh_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= WORD_BITS'(1);
      modulus_r  <= '1;
    end else begin
      exponent_r <= exponent_nxt;
      modulus_r  <= modulus_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    base_r   <= base_nxt;
    bsh_r    <= bsh_nxt;
    exp_sh_r <= exp_sh_nxt;
  end

  assign out_valid     = done;
  assign out_value_out = rme_pkg::FIELD_BITS'(res_r);

endmodule
